### rtl/sse_pkg.sv
// Shared types and constants of the sorted set engine.
package sse_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DEFAULT_KEY_BITS = 16;

  localparam int KEY_PORT_BITS = 16;
  localparam int OP_BITS       = 2;
  localparam int STATUS_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NOP    = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

### rtl/sorted_set_engine_top.sv
// Top level of the sorted set engine: request handling, the row of key cells and the result.
//
// The block keeps an ascending set of distinct keys, at most Capacity of them.
// The input channel (in_valid, in_ready, operation, key) carries one request per
// transaction: insert, delete or search a key. The output channel (out_valid,
// out_ready, status, entry_count) returns exactly one result per request.
// A request passes the accept state, then a compare state in which every
// cell compares its key with the request key in parallel, then an update state in which
// the row shifts one place to open or close a gap and the result is registered.
// out_valid is set by the update step, and a new request is taken only when the
// previous one is through. The result register lets a new request be accepted
// while the previous result still waits; if the receiver stalls, the update step
// holds until the waiting result is taken. Reset empties the set and the
// channels; key contents are not cleared, as only the first entry_count cells
// are ever read.
module sorted_set_engine_top #(
  parameter int Capacity = sse_pkg::DEFAULT_CAPACITY,
  parameter int KeyBits  = sse_pkg::DEFAULT_KEY_BITS,
  localparam int CntBits = $clog2(Capacity + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sse_pkg::OP_BITS-1:0]     operation,
  input  logic [sse_pkg::KEY_PORT_BITS-1:0] key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sse_pkg::STATUS_BITS-1:0] status,
  output logic [CntBits-1:0]              entry_count
);

  localparam int CopyBits = (KeyBits < sse_pkg::KEY_PORT_BITS) ? KeyBits
                                                                : sse_pkg::KEY_PORT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  logic [sse_pkg::OP_BITS-1:0]       req_op;
  logic [KeyBits-1:0]                req_key;
  logic [KeyBits-1:0]                key_in;
  logic [CntBits-1:0]                count;
  logic [CntBits-1:0]                count_next;
  logic [sse_pkg::STATUS_BITS-1:0]   status_next;
  sse_pkg::cell_cmd_t                cmd;
  logic                              present;
  logic                              full;
  logic                              update;

  logic [KeyBits-1:0] cell_key [Capacity];
  logic [Capacity-1:0] cell_lt;
  logic [Capacity-1:0] cell_eq;
  logic [Capacity-1:0] cell_occ;

  always_comb begin
    key_in = '0;
    key_in[CopyBits-1:0] = key[CopyBits-1:0];
  end

  assign in_ready = (state == S_IDLE);
  assign present  = |cell_eq;
  assign full     = (count == CntBits'(Capacity));
  assign update   = (state == S_UPD) && (!out_valid || out_ready);

  always_comb begin
    cmd         = '0;
    count_next  = count;
    status_next = sse_pkg::ST_MISS;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (update) begin
          state_next = S_IDLE;
          unique case (req_op)
            sse_pkg::OP_INSERT: begin
              if (present) begin
                status_next = sse_pkg::ST_MISS;
              end else if (full) begin
                status_next = sse_pkg::ST_FULL;
              end else begin
                cmd.ins     = 1'b1;
                count_next  = count + CntBits'(1);
                status_next = sse_pkg::ST_DONE;
              end
            end
            sse_pkg::OP_DELETE: begin
              if (present) begin
                cmd.del     = 1'b1;
                count_next  = count - CntBits'(1);
                status_next = sse_pkg::ST_DONE;
              end
            end
            sse_pkg::OP_SEARCH: begin
              if (present) begin
                status_next = sse_pkg::ST_DONE;
              end
            end
            default: begin
              status_next = sse_pkg::ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= operation;
      req_key <= key_in;
    end
    if (update) begin
      status      <= status_next;
      entry_count <= count_next;
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [KeyBits-1:0] left_key;
    logic               left_lt;
    logic [KeyBits-1:0] right_key;

    assign cell_occ[i] = (count > CntBits'(i));

    if (i == 0) begin : g_first
      assign left_key = req_key;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    sse_cell #(
      .KeyBits(KeyBits)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .req_key  (req_key),
      .occupied (cell_occ[i]),
      .left_key (left_key),
      .left_lt  (left_lt),
      .right_key(right_key),
      .key      (cell_key[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i])
    );
  end

endmodule

### rtl/sse_cell.sv
// One key cell of the sorted row: holds a key, compares it and shifts with its neighbours.
module sse_cell #(
  parameter int KeyBits = sse_pkg::DEFAULT_KEY_BITS
) (
  input  logic               clk,
  input  sse_pkg::cell_cmd_t cmd,
  input  logic [KeyBits-1:0] req_key,
  input  logic               occupied,
  input  logic [KeyBits-1:0] left_key,
  input  logic               left_lt,
  input  logic [KeyBits-1:0] right_key,
  output logic [KeyBits-1:0] key,
  output logic               lt,
  output logic               eq
);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt <= occupied && (key < req_key);
      eq <= occupied && (key == req_key);
    end
    if (cmd.ins && !lt) begin
      key <= left_lt ? req_key : left_key;
    end else if (cmd.del && !lt) begin
      key <= right_key;
    end
  end

endmodule

### tb/sse_checker.sv
`timescale 1ns / 100ps
// Checker of the sorted set engine: follows the key set, predicts every result and compares it.
module sse_checker #(
  parameter int CNT_BITS = $clog2(sse_pkg::DEFAULT_CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [sse_pkg::OP_BITS-1:0]       operation,
  input  logic [sse_pkg::KEY_PORT_BITS-1:0] key,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [sse_pkg::STATUS_BITS-1:0]   status,
  input  logic [CNT_BITS-1:0]               entry_count,
  output int                                pending,
  output int                                fail_count
);

  typedef struct packed {
    logic [sse_pkg::STATUS_BITS-1:0] status;
    logic [CNT_BITS-1:0]             count;
  } set_result_t;

  logic [sse_pkg::KEY_PORT_BITS-1:0] held_keys [sse_pkg::DEFAULT_CAPACITY];
  int                                held_count;
  set_result_t                       expected_results [$];

  function automatic set_result_t apply_request(logic [sse_pkg::OP_BITS-1:0] op,
                                                logic [sse_pkg::KEY_PORT_BITS-1:0] k);
    set_result_t res;
    int          pos;
    logic        hit;
    pos = 0;
    while (pos < held_count && held_keys[pos] < k) pos++;
    hit = (pos < held_count) && (held_keys[pos] == k);
    res.status = sse_pkg::ST_MISS;
    case (op)
      sse_pkg::OP_INSERT: begin
        if (!hit && held_count >= sse_pkg::DEFAULT_CAPACITY) begin
          res.status = sse_pkg::ST_FULL;
        end else if (!hit) begin
          for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = k;
          held_count++;
          res.status = sse_pkg::ST_DONE;
        end
      end
      sse_pkg::OP_DELETE: begin
        if (hit) begin
          for (int i = pos; i < held_count - 1; i++) held_keys[i] = held_keys[i+1];
          held_count--;
          res.status = sse_pkg::ST_DONE;
        end
      end
      sse_pkg::OP_SEARCH: begin
        if (hit) res.status = sse_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
    res.count = CNT_BITS'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < 40) $display("sse_checker: %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unrequested result, status %0d count %0d",
                                    status, entry_count));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
          if (entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                      entry_count, want.count));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_request(operation, key));
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top of the sorted set engine: clock, reset, stimulus, handshake pacing and verdict.
module tb_top;

  localparam int CNT_BITS    = $clog2(sse_pkg::DEFAULT_CAPACITY + 1);
  localparam int LONG_STALL  = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int POOL_SIZE   = 96;
  localparam int RUN_ITEMS   = 600;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [sse_pkg::OP_BITS-1:0]       operation = sse_pkg::OP_INSERT;
  logic [sse_pkg::KEY_PORT_BITS-1:0] key       = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [sse_pkg::STATUS_BITS-1:0]   status;
  logic [CNT_BITS-1:0]               entry_count;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_req          = 0;
  int hold_seen         = 0;
  int hold_left         = 0;
  int quiet_cycles      = 0;
  int pending;
  int fail_count;

  always #4 clk = ~clk;

  sorted_set_engine_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count)
  );

  sse_checker #(.CNT_BITS(CNT_BITS)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic offer(logic [sse_pkg::OP_BITS-1:0] op,
                       logic [sse_pkg::KEY_PORT_BITS-1:0] k);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_random(int n, int s_pct, int r_pct);
    int                                insert_pct;
    int                                roll;
    int                                idx;
    logic [sse_pkg::OP_BITS-1:0]       op;
    logic [sse_pkg::KEY_PORT_BITS-1:0] k;
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      case ((i / 100) % 3)
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      roll = $urandom_range(99);
      if (roll < insert_pct) op = sse_pkg::OP_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) / 2) op = sse_pkg::OP_DELETE;
      else op = sse_pkg::OP_SEARCH;
      if ($urandom_range(9) < 8) begin
        idx = $urandom_range(POOL_SIZE - 1);
        k   = (idx == POOL_SIZE - 1) ? '1 : sse_pkg::KEY_PORT_BITS'(idx * 691);
      end else begin
        k = sse_pkg::KEY_PORT_BITS'($urandom);
      end
      if (i == n / 3) hold_req++;
      if (i == (2 * n) / 3) drain();
      offer(op, k);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct   = 9;
    receiver_idle_pct = 57;
    offer(sse_pkg::OP_SEARCH, 16'h0000);
    offer(sse_pkg::OP_DELETE, 16'h0000);
    offer(sse_pkg::OP_NOP, 16'h1234);
    offer(sse_pkg::OP_INSERT, 16'h8000);
    offer(sse_pkg::OP_INSERT, 16'h0000);
    offer(sse_pkg::OP_INSERT, 16'hFFFF);
    offer(sse_pkg::OP_INSERT, 16'h7FFF);
    offer(sse_pkg::OP_INSERT, 16'hFFFE);
    offer(sse_pkg::OP_INSERT, 16'h0000);
    offer(sse_pkg::OP_INSERT, 16'h0001);
    offer(sse_pkg::OP_SEARCH, 16'hFFFF);
    offer(sse_pkg::OP_SEARCH, 16'h0002);
    offer(sse_pkg::OP_SEARCH, 16'h0000);
    offer(sse_pkg::OP_DELETE, 16'h8000);
    offer(sse_pkg::OP_DELETE, 16'h8000);
    offer(sse_pkg::OP_SEARCH, 16'h7FFF);
    offer(sse_pkg::OP_NOP, 16'hFFFF);
    offer(sse_pkg::OP_DELETE, 16'h0000);
    offer(sse_pkg::OP_DELETE, 16'hFFFF);
    offer(sse_pkg::OP_SEARCH, 16'hFFFE);

    run_random(RUN_ITEMS, 9, 57);
    run_random(RUN_ITEMS, 57, 9);
    run_random(RUN_ITEMS, 0, 0);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
